// ----- rtl/bitmap_frame_allocator_macros.svh -----
// Assertion macros for the checker file of the frame allocator.
`ifndef BITMAP_FRAME_ALLOCATOR_MACROS_SVH
`define BITMAP_FRAME_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define BFA_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define BFA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/bfa_pkg.sv -----
`timescale 1ns / 1ps

package bfa_pkg;

  // Geometry of the frame bitmap.
  localparam int MAX_FRAMES  = 32768;
  localparam int WORD_BITS   = 32;
  localparam int FRAME_SHIFT = 12;
  localparam int NWORDS      = MAX_FRAMES / WORD_BITS;
  localparam int WIDX_W      = $clog2(NWORDS);
  localparam int BIT_W       = $clog2(WORD_BITS);
  localparam int FIDX_W      = $clog2(MAX_FRAMES);
  localparam int PTR_W       = WIDX_W + 1;

  // Field widths.
  localparam int CNT_W       = 16;
  localparam int ADDR_W      = 32;
  localparam int KIND_W      = 2;
  localparam int STAT_W      = 2;
  localparam int CFG_IDX_W   = 1;

  // Output beat layout.
  localparam int OUT_STAT_LSB = ADDR_W;
  localparam int OUT_USED_LSB = ADDR_W + STAT_W;
  localparam int OUT_BITS     = ADDR_W + STAT_W + CNT_W;
  localparam int OUT_TDATA_W  = ((OUT_BITS + 7) / 8) * 8;

  // Reset values of the configuration registers.
  localparam logic [CNT_W-1:0] FRAME_COUNT_RST = CNT_W'(MAX_FRAMES);
  localparam logic [CNT_W-1:0] RESERVED_RST    = CNT_W'(256);

  typedef enum logic [KIND_W-1:0] {
    KIND_INIT  = 2'd0,
    KIND_ALLOC = 2'd1,
    KIND_FREE  = 2'd2,
    KIND_NOP   = 2'd3
  } kind_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK     = 2'd0,
    STAT_OOM    = 2'd1,
    STAT_DOUBLE = 2'd2,
    STAT_RANGE  = 2'd3
  } stat_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_COUNT = 1'b0,
    REG_RESERVED    = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_FILL,
    ST_IDLE,
    ST_INIT,
    ST_SCAN,
    ST_FREE_RD,
    ST_FREE_CHK,
    ST_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic nop;
    logic fill;
    logic init;
    logic scan;
    logic free_rd;
    logic free_chk;
    logic load_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic sweep_last;
    logic scan_done;
    logic free_oor;
  } sts_t;

endpackage

// ----- rtl/bfa_ctrl.sv -----
`timescale 1ns / 1ps

module bfa_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  input  logic [bfa_pkg::KIND_W-1:0]  s_tuser,
  output logic                        s_tready,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  input  bfa_pkg::sts_t               sts,
  output bfa_pkg::cmd_t               cmd
);
  import bfa_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_valid;
  kind_t  kind_in;

  assign kind_in  = kind_t'(s_tuser);
  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = out_valid;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_FILL;
    end else begin
      state <= state_next;
    end
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_FILL: begin
        if (sts.sweep_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (s_tvalid) begin
          unique case (kind_in)
            KIND_INIT:  state_next = ST_INIT;
            KIND_ALLOC: state_next = ST_SCAN;
            KIND_FREE:  state_next = ST_FREE_RD;
            KIND_NOP:   state_next = ST_DONE;
            default:    state_next = ST_DONE;
          endcase
        end
      end
      ST_INIT: begin
        if (sts.sweep_last) state_next = ST_DONE;
      end
      ST_SCAN: begin
        if (sts.scan_done) state_next = ST_DONE;
      end
      ST_FREE_RD: begin
        state_next = sts.free_oor ? ST_DONE : ST_FREE_CHK;
      end
      ST_FREE_CHK: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid || m_tready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Command outputs.
  always_comb begin
    cmd          = '0;
    cmd.capture  = (state == ST_IDLE) && s_tvalid;
    cmd.nop      = cmd.capture && (kind_in == KIND_NOP);
    cmd.fill     = (state == ST_FILL);
    cmd.init     = (state == ST_INIT);
    cmd.scan     = (state == ST_SCAN);
    cmd.free_rd  = (state == ST_FREE_RD);
    cmd.free_chk = (state == ST_FREE_CHK);
    cmd.load_out = (state == ST_DONE) && (!out_valid || m_tready);
  end

  // Output beat valid: set when a result is loaded, cleared when taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// ----- rtl/bfa_dp.sv -----
`timescale 1ns / 1ps

module bfa_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [bfa_pkg::ADDR_W-1:0]        s_tdata,
  input  logic                              cfg_we,
  input  logic [bfa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bfa_pkg::CNT_W-1:0]         cfg_data,
  input  bfa_pkg::cmd_t                     cmd,
  output bfa_pkg::sts_t                     sts,
  output logic [bfa_pkg::OUT_TDATA_W-1:0]   m_tdata
);
  import bfa_pkg::*;

  // Bits of word w whose frame index lies below limit.
  function automatic logic [WORD_BITS-1:0] below_mask(input logic [CNT_W-1:0] limit,
                                                       input logic [WIDX_W-1:0] w);
    logic [CNT_W-BIT_W-1:0] lw;
    lw = limit[CNT_W-1:BIT_W];
    if ({1'b0, w} < lw) begin
      return '1;
    end else if ({1'b0, w} == lw) begin
      return ~({WORD_BITS{1'b1}} << limit[BIT_W-1:0]);
    end else begin
      return '0;
    end
  endfunction

  logic [CNT_W-1:0]     frame_count;
  logic [CNT_W-1:0]     reserved_frames;
  logic [CNT_W-1:0]     fc_eff;
  logic [CNT_W-1:0]     rs_eff;

  logic [WORD_BITS-1:0] bitmap [NWORDS];
  logic [WORD_BITS-1:0] rdata;
  logic [WIDX_W-1:0]    raddr;
  logic                 mem_we;
  logic [WIDX_W-1:0]    waddr;
  logic [WORD_BITS-1:0] wdata;

  logic [PTR_W-1:0]     ptr;
  logic                 rd_v;
  logic [WIDX_W-1:0]    rd_w;
  logic                 issue;
  logic [FIDX_W-1:0]    fidx;
  logic                 oor_q;

  logic [WORD_BITS-1:0] free_bits;
  logic                 any_free;
  logic [BIT_W-1:0]     bsel;
  logic [FIDX_W-1:0]    hit_frame;
  logic                 scan_hit;
  logic                 fbit;

  logic [CNT_W-1:0]     used;
  logic [CNT_W-1:0]     used_next;

  logic [ADDR_W-1:0]    p_addr;
  logic [STAT_W-1:0]    p_status;
  logic [CNT_W-1:0]     p_used;
  logic [ADDR_W-1:0]    o_addr;
  logic [STAT_W-1:0]    o_status;
  logic [CNT_W-1:0]     o_used;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count     <= FRAME_COUNT_RST;
      reserved_frames <= RESERVED_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_FRAME_COUNT: frame_count     <= cfg_data;
        REG_RESERVED:    reserved_frames <= cfg_data;
        default:         frame_count     <= frame_count;
      endcase
    end
  end

  // Effective limits: count clamped to the bitmap, reserve clamped to the count.
  assign fc_eff = (frame_count > CNT_W'(MAX_FRAMES)) ? CNT_W'(MAX_FRAMES) : frame_count;
  assign rs_eff = (reserved_frames < fc_eff) ? reserved_frames : fc_eff;

  // Request capture for frees.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      fidx  <= s_tdata[FRAME_SHIFT +: FIDX_W];
      oor_q <= (s_tdata[ADDR_W-1:FRAME_SHIFT] >= (ADDR_W-FRAME_SHIFT)'(fc_eff));
    end
  end

  // Word pointer for sweeps and scans, and the read-valid flag of the scan.
  assign issue = ({ptr, {BIT_W{1'b0}}} < fc_eff);

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr  <= '0;
      rd_v <= 1'b0;
    end else if (cmd.capture) begin
      ptr  <= '0;
      rd_v <= 1'b0;
    end else if (cmd.fill || cmd.init) begin
      ptr  <= ptr + PTR_W'(1);
    end else if (cmd.scan) begin
      ptr  <= ptr + PTR_W'(1);
      rd_v <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      rd_w <= ptr[WIDX_W-1:0];
    end
  end

  // Lowest free bit of the word read last cycle.
  always_comb begin
    free_bits = ~rdata;
    any_free  = |free_bits;
    bsel      = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (free_bits[b]) bsel = BIT_W'(b);
    end
  end

  assign hit_frame = {rd_w, bsel};
  assign scan_hit  = rd_v && any_free && (CNT_W'(hit_frame) < fc_eff);
  assign fbit      = rdata[fidx[BIT_W-1:0]];

  assign sts.sweep_last = (ptr[WIDX_W-1:0] == WIDX_W'(NWORDS - 1));
  assign sts.scan_done  = rd_v ? (any_free || !issue) : !issue;
  assign sts.free_oor   = oor_q;

  // Bitmap read address and write port.
  always_comb begin
    raddr  = cmd.scan ? ptr[WIDX_W-1:0] : fidx[FIDX_W-1:BIT_W];
    mem_we = 1'b0;
    waddr  = ptr[WIDX_W-1:0];
    wdata  = '1;
    if (cmd.fill) begin
      mem_we = 1'b1;
    end else if (cmd.init) begin
      mem_we = 1'b1;
      wdata  = below_mask(rs_eff, ptr[WIDX_W-1:0]) | ~below_mask(fc_eff, ptr[WIDX_W-1:0]);
    end else if (cmd.scan && scan_hit) begin
      mem_we = 1'b1;
      waddr  = rd_w;
      wdata  = rdata | (WORD_BITS'(1) << bsel);
    end else if (cmd.free_chk && fbit) begin
      mem_we = 1'b1;
      waddr  = fidx[FIDX_W-1:BIT_W];
      wdata  = rdata & ~(WORD_BITS'(1) << fidx[BIT_W-1:0]);
    end
  end

  // Bitmap memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      bitmap[waddr] <= wdata;
    end
    rdata <= bitmap[raddr];
  end

  // Used-frame count, saturating at both ends.
  always_comb begin
    used_next = used;
    if (cmd.init && sts.sweep_last) begin
      used_next = rs_eff;
    end else if (cmd.scan && scan_hit && (used != '1)) begin
      used_next = used + CNT_W'(1);
    end else if (cmd.free_chk && fbit && (used != '0)) begin
      used_next = used - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= CNT_W'(MAX_FRAMES);
    end else begin
      used <= used_next;
    end
  end

  // Pending result, formed when an operation finishes.
  always_ff @(posedge clk) begin
    if (cmd.nop) begin
      p_addr   <= '0;
      p_status <= STAT_OK;
      p_used   <= used;
    end else if (cmd.init && sts.sweep_last) begin
      p_addr   <= '0;
      p_status <= STAT_OK;
      p_used   <= used_next;
    end else if (cmd.scan && sts.scan_done) begin
      p_addr   <= scan_hit ? ADDR_W'({hit_frame, {FRAME_SHIFT{1'b0}}}) : '0;
      p_status <= scan_hit ? STAT_OK : STAT_OOM;
      p_used   <= used_next;
    end else if (cmd.free_rd && oor_q) begin
      p_addr   <= '0;
      p_status <= STAT_RANGE;
      p_used   <= used;
    end else if (cmd.free_chk) begin
      p_addr   <= '0;
      p_status <= fbit ? STAT_OK : STAT_DOUBLE;
      p_used   <= used_next;
    end
  end

  // Output beat register.
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      o_addr   <= p_addr;
      o_status <= p_status;
      o_used   <= p_used;
    end
  end

  assign m_tdata = {{(OUT_TDATA_W - OUT_BITS){1'b0}}, o_used, o_status, o_addr};

endmodule

// ----- rtl/bitmap_frame_allocator.sv -----
`timescale 1ns / 1ps
// Init sweeps every bitmap word; alloc scans one bitmap word per cycle through the
// registered memory read; free reads the word of an in-range frame, then checks and clears its bit.
// One operation at a time; the next beat is taken the cycle after the result is
// handed to the output register, which may still be waiting on m_tready.
// Synchronous reset runs a pass that sets every bitmap word to all ones;
// s_tready stays low during that pass, configuration writes are taken throughout.

module bitmap_frame_allocator (
  input  logic                              clk,
  input  logic                              rst,
  // Input beat.
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [bfa_pkg::ADDR_W-1:0]        s_tdata,   // [31:0] frame_address
  input  logic [bfa_pkg::KIND_W-1:0]        s_tuser,   // [1:0] kind
  // Output beat.
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [bfa_pkg::OUT_TDATA_W-1:0]   m_tdata,   // [31:0] alloc_address,
                                                       // [33:32] status,
                                                       // [49:34] used_count, [55:50] zero
  // Configuration write port.
  input  logic                              cfg_we,
  input  logic [bfa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bfa_pkg::CNT_W-1:0]         cfg_data
);
  import bfa_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencer for the operations.
  bfa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tuser  (s_tuser),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Bitmap, counters and result registers.
  bfa_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .m_tdata   (m_tdata)
  );

endmodule

// ----- rtl/bfa_checker.sv -----
`timescale 1ns / 1ps
`include "bitmap_frame_allocator_macros.svh"

module bfa_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_tvalid,
  input logic                              s_tready,
  input logic                              m_tvalid,
  input logic                              m_tready,
  input logic [bfa_pkg::OUT_TDATA_W-1:0]   m_tdata
);
  import bfa_pkg::*;

  // A stalled output beat keeps its contents.
  `BFA_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "output beat changed while stalled")

  // Only one operation is in flight: taking a beat closes the input side.
  `BFA_ASSERT_NEXT(a_one_op, clk, rst, s_tvalid && s_tready, !s_tready, "input accepted twice in a row")

  // Any status other than ok carries a zero address.
  `BFA_ASSERT_SAME(a_err_addr, clk, rst, m_tvalid && (m_tdata[OUT_STAT_LSB +: STAT_W] != STAT_OK), m_tdata[ADDR_W-1:0] == '0, "error result with nonzero address")

  // Allocated addresses are frame aligned.
  `BFA_ASSERT_SAME(a_align, clk, rst, m_tvalid, m_tdata[FRAME_SHIFT-1:0] == '0, "unaligned frame address")

  // The used count never exceeds the bitmap size.
  `BFA_ASSERT_SAME(a_used_max, clk, rst, m_tvalid, m_tdata[OUT_USED_LSB +: CNT_W] <= CNT_W'(MAX_FRAMES), "used count above frame capacity")

endmodule

bind bitmap_frame_allocator bfa_checker u_bfa_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ----- test/bitmap_frame_allocator_tb.sv -----
`timescale 1ns / 1ps

module bitmap_frame_allocator_tb;
  import bfa_pkg::*;

  // Cycles without any beat on either side before the run is abandoned.
  localparam int STALL_LIMIT  = 20000;
  // Quiet time after the last result, longer than the slowest operation.
  localparam int DRAIN_CYCLES = 1100;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    stat_t             status;
    logic [CNT_W-1:0]  used;
  } frame_result_t;

  // Mirror of the frame bitmap and used count, plus the queue of results due.
  class frame_map_sb;
    logic [WORD_BITS-1:0] bitmap [NWORDS];
    int unsigned          used;
    logic [CNT_W-1:0]     frame_count;
    logic [CNT_W-1:0]     reserved;
    frame_result_t        due[$];
    logic [ADDR_W-1:0]    granted[$];
    int                   errors;

    function new();
      foreach (bitmap[i]) bitmap[i] = '1;
      used        = MAX_FRAMES;
      frame_count = FRAME_COUNT_RST;
      reserved    = RESERVED_RST;
      errors      = 0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [CNT_W-1:0] val);
      if (idx == REG_FRAME_COUNT) begin
        frame_count = val;
      end else begin
        reserved = val;
      end
    endfunction

    // Frame count clamped to what the bitmap can hold.
    function int unsigned managed();
      return (frame_count < MAX_FRAMES) ? frame_count : MAX_FRAMES;
    endfunction

    function int pending();
      return due.size();
    endfunction

    // Apply one accepted operation and queue the result it must produce.
    function void note_op(kind_t k, logic [ADDR_W-1:0] addr);
      frame_result_t        r;
      int unsigned          fc;
      int unsigned          rs;
      int unsigned          f;
      int unsigned          w;
      int unsigned          b;
      logic [WORD_BITS-1:0] open_bits;
      bit                   found;
      r.addr   = '0;
      r.status = STAT_OK;
      fc       = managed();
      case (k)
        KIND_INIT: begin
          // Reserved frames and frames past the count end up marked used.
          rs = (reserved < fc) ? reserved : fc;
          for (f = 0; f < MAX_FRAMES; f++) begin
            bitmap[f / WORD_BITS][f % WORD_BITS] = (f < rs) || (f >= fc);
          end
          used = rs;
          granted.delete();
        end
        KIND_ALLOC: begin
          // Only the first word holding a free bit is considered.
          found = 1'b0;
          f     = 0;
          for (w = 0; w < NWORDS && w * WORD_BITS < fc; w++) begin
            open_bits = ~bitmap[w];
            if (open_bits != '0) begin
              b = 0;
              while (!open_bits[b]) b++;
              f     = w * WORD_BITS + b;
              found = (f < fc);
              break;
            end
          end
          if (found) begin
            bitmap[f / WORD_BITS][f % WORD_BITS] = 1'b1;
            if (used != 32'hFFFF_FFFF) used++;
            r.addr = f << FRAME_SHIFT;
            granted.push_back(r.addr);
          end else begin
            r.status = STAT_OOM;
          end
        end
        KIND_FREE: begin
          f = addr >> FRAME_SHIFT;
          if (f >= fc) begin
            r.status = STAT_RANGE;
          end else if (!bitmap[f / WORD_BITS][f % WORD_BITS]) begin
            r.status = STAT_DOUBLE;
          end else begin
            bitmap[f / WORD_BITS][f % WORD_BITS] = 1'b0;
            if (used != 0) used--;
          end
        end
        default: begin
        end
      endcase
      r.used = used[CNT_W-1:0];
      due.push_back(r);
    endfunction

    // Compare one output beat with the oldest result due.
    function void check_beat(logic [OUT_TDATA_W-1:0] beat);
      frame_result_t     e;
      logic [ADDR_W-1:0] a;
      logic [STAT_W-1:0] s;
      logic [CNT_W-1:0]  u;
      a = beat[ADDR_W-1:0];
      s = beat[OUT_STAT_LSB +: STAT_W];
      u = beat[OUT_USED_LSB +: CNT_W];
      if (due.size() == 0) begin
        $error("result beat with nothing pending: %h", beat);
        errors++;
        return;
      end
      e = due.pop_front();
      if (a !== e.addr) begin
        $error("alloc_address: expected %h, actual %h", e.addr, a);
        errors++;
      end
      if (s !== e.status) begin
        $error("status: expected %0d, actual %0d", e.status, s);
        errors++;
      end
      if (u !== e.used) begin
        $error("used_count: expected %0d, actual %0d", e.used, u);
        errors++;
      end
    endfunction
  endclass

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [ADDR_W-1:0]      s_tdata;
  logic [KIND_W-1:0]      s_tuser;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CNT_W-1:0]       cfg_data;

  frame_map_sb sb;
  int          burst_left = 0;
  int          rx_mode = 0;
  int          mode_left = 0;
  int          tick = 0;
  int          idle_cycles = 0;

  bitmap_frame_allocator uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Receiver: switches between always ready, coin flips and periodic stalls.
  always @(posedge clk) begin
    if (mode_left == 0) begin
      rx_mode   = $urandom_range(0, 3);
      mode_left = $urandom_range(20, 300);
    end else begin
      mode_left--;
    end
    tick++;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      case (rx_mode)
        0: m_tready <= 1'b1;
        1: m_tready <= 1'($urandom_range(0, 1));
        2: m_tready <= (tick % 8 == 0);
        default: m_tready <= (tick % 3 != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_beat(m_tdata);
  end

  // Watchdog on cycles with no beat moving in either direction.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Send one operation; the sender may pause between bursts of random length.
  task automatic send_op(kind_t k, logic [ADDR_W-1:0] addr);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tuser  <= k;
    s_tdata  <= addr;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_op(k, addr);
  endtask

  // Stop sending and wait until every result has come back.
  task automatic settle();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Write both registers on consecutive cycles, once no result is pending.
  task automatic set_geometry(logic [CNT_W-1:0] fc, logic [CNT_W-1:0] rs);
    cfg_we    <= 1'b1;
    cfg_index <= REG_FRAME_COUNT;
    cfg_data  <= fc;
    @(posedge clk);
    sb.write_reg(REG_FRAME_COUNT, fc);
    cfg_index <= REG_RESERVED;
    cfg_data  <= rs;
    @(posedge clk);
    sb.write_reg(REG_RESERVED, rs);
    cfg_we <= 1'b0;
  endtask

  // Mostly alloc and free of granted frames, with some noise on top.
  task automatic issue_random();
    int                r;
    int                idx;
    int unsigned       top;
    logic [ADDR_W-1:0] a;
    r   = $urandom_range(0, 99);
    top = sb.managed() + sb.managed() / 8 + 2;
    if (r < 3) begin
      send_op(KIND_INIT, $urandom);
    end else if (r < 7) begin
      send_op(KIND_NOP, $urandom);
    end else if (r < 50) begin
      send_op(KIND_ALLOC, $urandom);
    end else if (r < 75 && sb.granted.size() > 0) begin
      idx = $urandom_range(0, sb.granted.size() - 1);
      a   = sb.granted[idx] | ADDR_W'($urandom_range(0, 4095));
      sb.granted.delete(idx);
      send_op(KIND_FREE, a);
    end else if (r < 90) begin
      a = (ADDR_W'($urandom_range(0, top)) << FRAME_SHIFT) | ADDR_W'($urandom_range(0, 4095));
      send_op(KIND_FREE, a);
    end else begin
      send_op(KIND_FREE, $urandom);
    end
  endtask

  task automatic run_phase(logic [CNT_W-1:0] fc, logic [CNT_W-1:0] rs, bit do_init, int n);
    settle();
    set_geometry(fc, rs);
    if (do_init) send_op(KIND_INIT, $urandom);
    repeat (n) issue_random();
  endtask

  initial begin
    sb = new();
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= KIND_NOP;
    cfg_we    <= 1'b0;
    cfg_index <= REG_FRAME_COUNT;
    cfg_data  <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed checks on the all-used map left by reset.
    settle();
    set_geometry(16'd32768, 16'd256);
    send_op(KIND_NOP, 32'hFFFF_FFFF);
    send_op(KIND_FREE, 32'h0000_0FFF);   // frame 0, offset bits ignored
    send_op(KIND_FREE, 32'h0000_0000);   // already free
    send_op(KIND_FREE, 32'hFFFF_F000);   // far out of range
    send_op(KIND_FREE, 32'h0800_0000);   // first frame past the count
    send_op(KIND_FREE, 32'h07FF_F000);   // last frame
    send_op(KIND_ALLOC, 32'h0);
    send_op(KIND_ALLOC, 32'hFFFF_FFFF);  // finds the last frame after a full scan
    send_op(KIND_ALLOC, 32'h0);          // nothing left
    send_op(KIND_INIT, 32'hFFFF_FFFF);
    send_op(KIND_ALLOC, 32'h0);          // first frame past the reserved area
    send_op(KIND_FREE, 32'h0010_0000);
    send_op(KIND_FREE, 32'h000F_F000);   // reserved frame released
    repeat (50) issue_random();

    run_phase(16'd32768, 16'd256, 1'b1, 100);
    run_phase(16'd64, 16'd0, 1'b1, 70);
    // Partial last word.
    run_phase(16'd37, 16'd5, 1'b1, 70);
    // Reserved area larger than the count.
    run_phase(16'd100, 16'd200, 1'b1, 45);
    // Count beyond the bitmap size.
    run_phase(16'd40000, 16'd65535, 1'b1, 35);
    run_phase(16'd0, 16'd0, 1'b1, 30);
    run_phase(16'd65535, 16'd0, 1'b1, 60);

    // Grow the count after init: the used count saturates at zero.
    run_phase(16'd64, 16'd0, 1'b1, 0);
    run_phase(16'd128, 16'd0, 1'b0, 0);
    send_op(KIND_FREE, 32'h0004_0000);
    send_op(KIND_FREE, 32'h0007_F000);
    repeat (45) issue_random();

    // Shrink the count after init: free bits past it are never handed out.
    run_phase(16'd50, 16'd0, 1'b0, 40);

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
